[src/packed_symmetric_matvec_accumulate_top_assert.svh]
// ----------------------------------------------------------------------------
// psmva assertion macros
// Shared property forms for the packed symmetric matrix-vector block.
// ----------------------------------------------------------------------------
`ifndef PACKED_SYMMETRIC_MATVEC_ACCUMULATE_TOP_ASSERT_SVH
`define PACKED_SYMMETRIC_MATVEC_ACCUMULATE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PSMVA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("psmva assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PSMVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("psmva assertion failed");

`endif

[src/psmva_pkg.sv]
// ----------------------------------------------------------------------------
// psmva_pkg
// Types, codes and arithmetic helpers of the packed symmetric matvec block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psmva_pkg;

	// request kind codes
	localparam logic [1:0] KIND_MAT = 2'd0;
	localparam logic [1:0] KIND_VEC = 2'd1;
	localparam logic [1:0] KIND_RUN = 2'd2;

	// run mode codes (anything else adds)
	localparam logic [1:0] MODE_SUB  = 2'd1;
	localparam logic [1:0] MODE_QUAD = 2'd2;

	// configuration register index and reset value
	localparam logic       CFG_IDX_ACTIVE_SIZE = 1'b0;
	localparam logic [5:0] ACTIVE_SIZE_RST     = 6'd32;

	// widths
	localparam int N_W      = 7;   // holds an order up to 64
	localparam int ACC_W    = 56;  // exact sum of up to 127 floored products
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	typedef struct packed {
		logic [1:0]         kind;
		logic [9:0]         position;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic [1:0]         mode;
	} in_item_t;

	typedef struct packed {
		logic [4:0]         element_index;
		logic signed [31:0] element_value;
		logic signed [63:0] quadratic;
		logic               last;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_MAT,
		OP_VEC,
		OP_RUN
	} cmd_op_t;

	// classified request passed from front to back
	typedef struct packed {
		cmd_op_t            op;
		logic [9:0]         addr;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic               sub;
		logic               quad;
		logic [N_W-1:0]     n;
	} cmd_t;

	// exact signed 32x32 product
	function automatic logic signed [63:0] mul32(input logic signed [31:0] x,
			input logic signed [31:0] y);
		return x * y;
	endfunction

	// Q32.32 to Q40.16, rounded toward minus infinity, sign extended
	function automatic logic signed [ACC_W-1:0] floor_q16(input logic signed [63:0] p);
		return ACC_W'($signed(p[63:16]));
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [ACC_W:0] x);
		if (x[ACC_W:31] == {(ACC_W - 30){x[ACC_W]}}) begin
			return x[31:0];
		end
		if (x[ACC_W]) begin
			return {1'b1, {31{1'b0}}};
		end
		return {1'b0, {31{1'b1}}};
	endfunction

	// saturating signed 64-bit add
	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic signed [64:0] s;
		s = 65'(x) + 65'(y);
		if (s[64] == s[63]) begin
			return s[63:0];
		end
		if (s[64]) begin
			return {1'b1, {63{1'b0}}};
		end
		return {1'b0, {63{1'b1}}};
	endfunction

endpackage

`default_nettype wire

[src/psmva_ram.sv]
// ----------------------------------------------------------------------------
// psmva_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psmva_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/psmva_fifo.sv]
// ----------------------------------------------------------------------------
// psmva_fifo
// Small register queue used between front and back and for results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psmva_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PW + 1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PW + 1)'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

[src/psmva_front.sv]
// ----------------------------------------------------------------------------
// psmva_front
// Queues decoded requests; drops unknown kinds and out-of-range loads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psmva_front #(
	parameter int MAX_ORDER = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire psmva_pkg::in_item_t request,
	input  wire logic [5:0]          active_size,
	output logic                     cmd_valid,
	input  wire logic                cmd_pop,
	output psmva_pkg::cmd_t          cmd
);

	import psmva_pkg::*;

	localparam int STORE_DEPTH = (MAX_ORDER * (MAX_ORDER + 1)) / 2;

	cmd_t           cmd_new;
	logic           keep;
	logic [N_W-1:0] size_ext;
	logic [N_W-1:0] order;
	logic           q_empty;

	// clamp the configured order to 1..MAX_ORDER
	always_comb begin
		size_ext = N_W'(active_size);
		if (size_ext == '0) begin
			order = N_W'(1);
		end else if (size_ext > N_W'(MAX_ORDER)) begin
			order = N_W'(MAX_ORDER);
		end else begin
			order = size_ext;
		end
	end

	// classify the request
	always_comb begin
		cmd_new.addr = request.position;
		cmd_new.a    = request.value_a;
		cmd_new.b    = request.value_b;
		cmd_new.sub  = (request.mode == MODE_SUB);
		cmd_new.quad = (request.mode == MODE_QUAD);
		cmd_new.n    = order;
		unique case (request.kind)
			KIND_MAT: begin
				cmd_new.op = OP_MAT;
				keep       = (32'(request.position) < STORE_DEPTH);
			end
			KIND_VEC: begin
				cmd_new.op = OP_VEC;
				keep       = (32'(request.position) < MAX_ORDER);
			end
			KIND_RUN: begin
				cmd_new.op = OP_RUN;
				keep       = 1'b1;
			end
			default: begin
				cmd_new.op = OP_RUN;
				keep       = 1'b0;
			end
		endcase
	end

	// command queue toward the back end
	psmva_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !full && keep),
		.wdata (cmd_new),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd),
		.empty (q_empty)
	);

	assign cmd_valid = !q_empty;

endmodule

`default_nettype wire

[src/psmva_back.sv]
// ----------------------------------------------------------------------------
// psmva_back
// Executes loads and walks the packed matrix for runs, emitting one result
// per accumulator element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "packed_symmetric_matvec_accumulate_top_assert.svh"

module psmva_back #(
	parameter int MAX_ORDER = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	input  wire psmva_pkg::cmd_t  cmd,
	output logic                  cmd_pop,
	output logic                  res_push,
	output psmva_pkg::out_item_t  res,
	input  wire logic             res_full
);

	import psmva_pkg::*;

	localparam int STORE_DEPTH = (MAX_ORDER * (MAX_ORDER + 1)) / 2;
	localparam int MAW         = $clog2(STORE_DEPTH);
	localparam int IW          = $clog2(MAX_ORDER);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_MUL,
		S_ACC,
		S_ERD,
		S_UPD,
		S_QMUL,
		S_EMIT
	} state_t;

	state_t                   state_q;
	logic [IW-1:0]            i_q;
	logic [IW-1:0]            k_q;
	logic [IW-1:0]            nl_q;
	logic [MAW-1:0]           idx_q;
	logic                     sub_q;
	logic                     quad_q;
	logic signed [63:0]       qsum_q;

	logic signed [31:0]       vi_q;
	logic signed [31:0]       r_q;
	logic signed [63:0]       p1_q;
	logic signed [63:0]       p2_q;
	logic signed [63:0]       qp_q;
	logic signed [ACC_W-1:0]  row_q;

	logic                     mat_we;
	logic [MAW-1:0]           mat_waddr;
	logic                     mat_re;
	logic signed [31:0]       mat_rdata;
	logic                     vec_we;
	logic [IW-1:0]            vec_waddr;
	logic                     vec_re;
	logic signed [31:0]       vec_rdata;
	logic                     acc_we;
	logic [IW-1:0]            acc_waddr;
	logic signed [31:0]       acc_wdata;
	logic                     acc_re;
	logic signed [31:0]       acc_rdata;
	logic                     off_we;
	logic                     off_re;
	logic signed [ACC_W-1:0]  off_wdata;
	logic signed [ACC_W-1:0]  off_rdata;

	logic                     cmd_go;
	logic                     diag;
	logic                     row_end;
	logic                     last_row;
	logic signed [31:0]       vi_eff;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  t1;
	logic signed [ACC_W-1:0]  t2;
	logic signed [ACC_W:0]    upd_sum;
	logic signed [31:0]       r_new;
	logic signed [63:0]       q_next;

	// walk position and shared arithmetic
	assign cmd_go   = (state_q == S_IDLE) && cmd_valid;
	assign cmd_pop  = cmd_go;
	assign diag     = (k_q == i_q);
	assign row_end  = (k_q == nl_q);
	assign last_row = (i_q == nl_q);
	assign vi_eff   = diag ? vec_rdata : vi_q;
	// off-diagonal partial sums exist only once row 0 has written them
	assign base     = (i_q == '0) ? '0 : off_rdata;
	assign t1       = floor_q16(p1_q);
	assign t2       = floor_q16(p2_q);
	assign upd_sum  = sub_q ? ((ACC_W + 1)'(acc_rdata) - (ACC_W + 1)'(row_q))
	                        : ((ACC_W + 1)'(acc_rdata) + (ACC_W + 1)'(row_q));
	assign r_new    = sat32(upd_sum);
	assign q_next   = sat_add64(qsum_q, qp_q);

	// memory ports: loads from idle, walk reads and write-backs otherwise
	assign mat_we    = cmd_go && (cmd.op == OP_MAT);
	assign mat_waddr = MAW'(cmd.addr);
	assign mat_re    = (state_q == S_RD);
	assign vec_we    = cmd_go && (cmd.op == OP_VEC);
	assign vec_waddr = IW'(cmd.addr);
	assign vec_re    = (state_q == S_RD);
	assign acc_we    = vec_we || (state_q == S_UPD);
	assign acc_waddr = (state_q == S_UPD) ? i_q : IW'(cmd.addr);
	assign acc_wdata = (state_q == S_UPD) ? r_new : cmd.b;
	assign acc_re    = (state_q == S_ERD);
	assign off_we    = (state_q == S_ACC) && !diag;
	assign off_wdata = base + t2;
	assign off_re    = (state_q == S_RD);

	psmva_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_mat_ram (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(cmd.a),
		.re(mat_re), .raddr(idx_q), .rdata(mat_rdata)
	);

	psmva_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_vec_ram (
		.clk(clk), .we(vec_we), .waddr(vec_waddr), .wdata(cmd.a),
		.re(vec_re), .raddr(k_q), .rdata(vec_rdata)
	);

	psmva_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_acc_ram (
		.clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
		.re(acc_re), .raddr(i_q), .rdata(acc_rdata)
	);

	psmva_ram #(.WIDTH(ACC_W), .DEPTH(MAX_ORDER)) u_off_ram (
		.clk(clk), .we(off_we), .waddr(k_q), .wdata(off_wdata),
		.re(off_re), .raddr(k_q), .rdata(off_rdata)
	);

	// result request
	assign res_push            = (state_q == S_EMIT) && !res_full;
	assign res.element_index   = 5'(i_q);
	assign res.element_value   = r_q;
	assign res.quadratic       = quad_q ? q_next : '0;
	assign res.last            = last_row;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			k_q     <= '0;
			nl_q    <= '0;
			idx_q   <= '0;
			sub_q   <= 1'b0;
			quad_q  <= 1'b0;
			qsum_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_go && (cmd.op == OP_RUN)) begin
						sub_q   <= cmd.sub;
						quad_q  <= cmd.quad;
						nl_q    <= IW'(cmd.n - N_W'(1));
						i_q     <= '0;
						k_q     <= '0;
						idx_q   <= '0;
						qsum_q  <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					idx_q <= idx_q + MAW'(1);
					if (row_end) begin
						state_q <= S_ERD;
					end else begin
						k_q     <= k_q + IW'(1);
						state_q <= S_RD;
					end
				end
				S_ERD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					state_q <= S_QMUL;
				end
				S_QMUL: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!res_full) begin
						if (quad_q) begin
							qsum_q <= q_next;
						end
						if (last_row) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + IW'(1);
							k_q     <= i_q + IW'(1);
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			p1_q <= mul32(mat_rdata, vec_rdata);
			p2_q <= mul32(mat_rdata, vi_eff);
			if (diag) begin
				vi_q <= vec_rdata;
			end
		end
		if (state_q == S_ACC) begin
			row_q <= diag ? (base + t1) : (row_q + t1);
		end
		if (state_q == S_UPD) begin
			r_q <= r_new;
		end
		if (state_q == S_QMUL) begin
			qp_q <= mul32(r_q, vi_q);
		end
	end

	// walk stays inside the upper triangle of the active order
	`PSMVA_ASSERT_IMPL(a_walk_bounds, clk, arst_n, (state_q != S_IDLE), (k_q >= i_q && k_q <= nl_q))
	// packed word index never leaves the matrix store
	`PSMVA_ASSERT_IMPL(a_store_bound, clk, arst_n, (state_q == S_RD), (32'(idx_q) < STORE_DEPTH))
	// the final element ends the run
	`PSMVA_ASSERT_NEXT(a_last_done, clk, arst_n, (res_push && res.last), (state_q == S_IDLE))

endmodule

`default_nettype wire

[src/packed_symmetric_matvec_accumulate_top.sv]
// ----------------------------------------------------------------------------
// packed_symmetric_matvec_accumulate_top
// Symmetric packed matrix times vector, accumulated into a stored vector.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on push/full; results leave on empty/pop, oldest first.
//   Kind 0 loads one packed upper-triangular matrix word, kind 1 loads one
//   input vector element and its accumulator element, kind 2 runs the update
//   and returns n results (one per element, last set on the final one).
//   The APB port holds active_size (order n) at address 0.
//   The back end executes loads from its idle state; a command queue lets
//   the front keep taking requests while the back end is busy.
//   A run steps through a memory read, multiply and accumulate for each packed
//   matrix word, then an accumulator read, update, quadratic product and emit
//   for each element; the first result follows the walk of the first row.
//   If the receiver stops popping, the result queue fills and the back end
//   waits at its emit step; the command queue then fills and full rises.
//   Reset empties both queues, clears the quadratic sum and sets n to 32.
//   Matrix, vector and accumulator contents are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packed_symmetric_matvec_accumulate_top #(
	parameter int MAX_ORDER = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire psmva_pkg::in_item_t  request,
	output logic                      empty,
	input  wire logic                 pop,
	output psmva_pkg::out_item_t      result,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready
);

	import psmva_pkg::*;

	logic [5:0] active_size_q;
	logic       cfg_wr;
	logic       cmd_valid;
	logic       cmd_pop;
	cmd_t       cmd;
	logic       res_push;
	logic       res_full;
	out_item_t  res;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_ACTIVE_SIZE);
	assign prdata = (paddr[2] == CFG_IDX_ACTIVE_SIZE) ? 32'(active_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q <= ACTIVE_SIZE_RST;
		end else if (cfg_wr) begin
			active_size_q <= pwdata[5:0];
		end
	end

	// request intake and classification
	psmva_front #(.MAX_ORDER(MAX_ORDER)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.request    (request),
		.active_size(active_size_q),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd)
	);

	// execution
	psmva_back #(.MAX_ORDER(MAX_ORDER)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full)
	);

	// result queue
	psmva_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule

`default_nettype wire
